### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the modular inverse unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/core/mie_pkg.sv
// Shared types and constants of the modular inverse unit.
package mie_pkg;
	localparam int WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic align_shift;
		logic div;
		logic update;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic r1_zero;
		logic fits;
		logic last;
	} sts_t;
endpackage

### rtl/core/mie_ctrl.sv
// Sequencer that steps the shared divide unit through the Euclid iterations.
module mie_ctrl
	import mie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);
	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_next = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				// A zero remainder ends the algorithm; otherwise line the divisor
				// up under the dividend one bit a cycle.
				if (sts.r1_zero) begin
					state_next = ST_FINISH;
				end else if (sts.fits) begin
					ctl.align_shift = 1'b1;
				end else begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (sts.last) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				state_next = ST_ALIGN;
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

### rtl/core/mie_datapath.sv
// Remainder and coefficient registers around one shift-subtract-accumulate unit.
module mie_datapath
	import mie_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output sts_t             sts,
	output logic             done,
	output logic [WIDTH-1:0] inverse,
	output logic [WIDTH-1:0] divisor,
	output logic             has_inverse
);
	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] r0_q, r1_q, rem_q, d_q, s0_q, s1_q, acc_q, m_q;
	logic [CW-1:0]    k_q;
	logic             odd_q;

	logic             ge;
	logic [WIDTH-1:0] rem_sub, acc_next, s_next;
	logic [WIDTH-1:0] red, inv_val;
	logic             ok;

	assign ge       = (rem_q >= d_q);
	assign rem_sub  = rem_q - d_q;
	// The quotient comes out high bit first, so q*s1 builds up by shift and add.
	assign acc_next = {acc_q[WIDTH-2:0], 1'b0} + (ge ? s1_q : '0);
	assign s_next   = s0_q + acc_q;

	assign sts.r1_zero = (r1_q == '0);
	assign sts.fits    = ({d_q, 1'b0} <= {1'b0, rem_q});
	assign sts.last    = (k_q == '0);

	// The final coefficient magnitude stays below twice the modulus.
	assign red     = (s0_q >= m_q) ? (s0_q - m_q) : s0_q;
	assign ok      = (r0_q == {{(WIDTH-1){1'b0}}, 1'b1}) && (m_q != '0);
	assign inv_val = (odd_q && (red != '0)) ? (m_q - red) : red;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r0_q  <= value;
			r1_q  <= modulus;
			m_q   <= modulus;
			rem_q <= value;
			d_q   <= modulus;
			s0_q  <= {{(WIDTH-1){1'b0}}, 1'b1};
			s1_q  <= '0;
			acc_q <= '0;
			k_q   <= '0;
			odd_q <= 1'b0;
		end else if (ctl.align_shift) begin
			d_q <= {d_q[WIDTH-2:0], 1'b0};
			k_q <= k_q + CW'(1);
		end else if (ctl.div) begin
			if (ge) begin
				rem_q <= rem_sub;
			end
			acc_q <= acc_next;
			d_q   <= {1'b0, d_q[WIDTH-1:1]};
			k_q   <= k_q - CW'(1);
		end else if (ctl.update) begin
			// Shift the remainder pair and preset the divider for the next step.
			r0_q  <= r1_q;
			r1_q  <= rem_q;
			s0_q  <= s1_q;
			s1_q  <= s_next;
			odd_q <= ~odd_q;
			rem_q <= r1_q;
			d_q   <= rem_q;
			acc_q <= '0;
			k_q   <= '0;
		end
		if (ctl.finish) begin
			divisor     <= r0_q;
			has_inverse <= ok;
			inverse     <= ok ? inv_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.finish;
		end
	end
endmodule

### rtl/core/modular_inverse_ext_euclid_unit.sv
// Top level of the modular inverse unit based on the extended Euclidean algorithm.
// Usage: drive value and modulus and raise start while busy is low; the item is
// taken at that clock edge and busy rises on the next cycle.
// The unit runs the Euclid remainder sequence with one shift-subtract divider
// that also accumulates the quotient times the running Bezout coefficient.
// Each Euclid step shifts the divisor up under the remainder (ALIGN, ending once
// twice the divisor exceeds the remainder), then subtracts and shifts it back down
// one quotient bit at a time (DIV) and updates the registers (UPDATE); the
// sequence ends with one more check and a finishing state (FINISH). The time an
// item takes depends on its operands, and start is taken only while idle.
// The result is registered on inverse, divisor and has_inverse as done goes high
// for exactly one cycle, in the cycle in which busy has already fallen, so the next
// item may be started while the result is on the ports.
// The receiver cannot hold a result off; it must take it in that cycle.
// inverse lies in 0..modulus-1 and is zero when no inverse exists.
// Reset, asynchronous and active low, returns the sequencer to idle and clears
// done; an item in flight is dropped.
`include "assert_macros.svh"
module modular_inverse_ext_euclid_unit
	import mie_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output logic             done,
	output logic [WIDTH-1:0] inverse,
	output logic [WIDTH-1:0] divisor,
	output logic             has_inverse
);
	ctl_t ctl;
	sts_t sts;

	mie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	mie_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.value       (value),
		.modulus     (modulus),
		.sts         (sts),
		.done        (done),
		.inverse     (inverse),
		.divisor     (divisor),
		.has_inverse (has_inverse)
	);

	`ASSERT_PROP(a_done_single, clk, arst_n, done |=> !done)
	`ASSERT_PROP(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_PROP(a_inv_gcd_one, clk, arst_n, (done && has_inverse) |-> (divisor == 1))
	`ASSERT_NEVER(a_inv_zero, clk, arst_n, done && !has_inverse && (inverse != '0))
endmodule
